FILE: src/dcnb_pkg.sv
// Package of shared widths, constants, register indexes and types for the notch biquad.
package dcnb_pkg;

    // Channel count and the width of the channel selector.
    localparam int CHANNELS   = 2;
    localparam int CHAN_W     = 1;

    // Field and history widths.
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 16;
    localparam int XH_W       = 28;
    localparam int YH_W       = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Both scale factors are powers of two, so they are kept as shift counts.
    localparam int IN_SHIFT   = 4;     // input multiplier of 16
    localparam int COEF_SHIFT = 14;    // coefficient scale of 16384

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COEFS_CH0   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFS_CH1   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd2;

    // One channel's coefficient register: b0 in the low bits, a2 in the high bits.
    typedef struct packed {
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b0;
    } coef_t;

    // One channel's filter history.
    typedef struct packed {
        logic signed [XH_W-1:0] x1;
        logic signed [XH_W-1:0] x2;
        logic signed [YH_W-1:0] y1;
        logic signed [YH_W-1:0] y2;
    } hist_t;

endpackage

FILE: src/dual_channel_notch_biquad.sv
// Top level of the two-channel fixed-point direct-form-I notch biquad.
//
// Usage: each input word on the s_ channel carries a signed 24-bit sample in
// s_tdata and its channel number in s_tuser. Each accepted word produces
// exactly one output word on the m_ channel, in the same order. An enabled
// channel runs the sample through its notch filter and updates that channel's
// history; a disabled channel passes the sample through untouched.
// The configuration channel writes the two coefficient registers and the
// enable mask. Writing a coefficient register also clears that channel's
// history. Configuration is meant to be written while no word is in flight.
// An accepted word is held in the input register, and from there the full
// biquad (five products, sum, scaling and saturation) evaluates combinationally
// into the output register, which drives m_tvalid and m_tdata. While m_tready
// stays high, throughput is one word per cycle, also for consecutive words
// on the same channel, because the history written at the end of one word is
// read by the next word directly. The cycle time is set by that combinational
// multiply, sum and saturate path. Reset clears the coefficients, the enable
// mask, all histories and any words in flight. When the receiver holds m_tready
// low, the output word waits in the output register, one more word is still
// taken into the input register, and then s_tready drops until the output moves.
module dual_channel_notch_biquad (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dcnb_pkg::SAMPLE_W-1:0]       s_tdata,    // [23:0] sample_in
    input  logic [dcnb_pkg::CHAN_W-1:0]         s_tuser,    // [0] channel
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dcnb_pkg::SAMPLE_W-1:0]       m_tdata,    // [23:0] sample_out
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcnb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dcnb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration and filter state.
    logic [dcnb_pkg::CFG_DATA_W-1:0]     coefs_reg [dcnb_pkg::CHANNELS];
    logic [dcnb_pkg::CHANNELS-1:0]       enable_reg;
    dcnb_pkg::hist_t                     hist_reg  [dcnb_pkg::CHANNELS];

    // Input register.
    logic                                s1_valid_reg;
    logic [dcnb_pkg::CHAN_W-1:0]         s1_chan_reg;
    logic signed [dcnb_pkg::SAMPLE_W-1:0] s1_sample_reg;

    // Output register.
    logic                                m_valid_reg;
    logic [dcnb_pkg::SAMPLE_W-1:0]       m_data_reg;
    logic [dcnb_pkg::SAMPLE_W-1:0]       m_data_next;

    logic                                s_accept;
    logic                                advance;
    logic                                filt_en;
    dcnb_pkg::coef_t                     coef_sel;
    dcnb_pkg::hist_t                     hist_next;
    logic signed [dcnb_pkg::SAMPLE_W-1:0] filt_out;

    // The input register moves forward whenever the output register is empty or
    // is being emptied in this cycle.
    assign advance   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign coef_sel  = dcnb_pkg::coef_t'(coefs_reg[s1_chan_reg]);
    assign filt_en   = enable_reg[s1_chan_reg];

    dcnb_datapath u_datapath (
        .sample_in  (s1_sample_reg),
        .coef       (coef_sel),
        .hist       (hist_reg[s1_chan_reg]),
        .hist_next  (hist_next),
        .sample_out (filt_out)
    );

    // A disabled channel returns its sample unchanged.
    assign m_data_next = filt_en ? filt_out : s1_sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            enable_reg   <= '0;
            for (int c = 0; c < dcnb_pkg::CHANNELS; c++) begin
                coefs_reg[c] <= '0;
                hist_reg[c]  <= '0;
            end
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end

            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (advance && filt_en) begin
                hist_reg[s1_chan_reg] <= hist_next;
            end

            // Configuration comes last so that a coefficient write wins the history.
            if (cfg_valid) begin
                unique case (cfg_index)
                    dcnb_pkg::REG_COEFS_CH0: begin
                        coefs_reg[0] <= cfg_data;
                        hist_reg[0]  <= '0;
                    end
                    dcnb_pkg::REG_COEFS_CH1: begin
                        coefs_reg[1] <= cfg_data;
                        hist_reg[1]  <= '0;
                    end
                    dcnb_pkg::REG_ENABLE_MASK: begin
                        enable_reg <= cfg_data[dcnb_pkg::CHANNELS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_chan_reg   <= s_tuser;
            s1_sample_reg <= signed'(s_tdata);
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

FILE: src/dcnb_datapath.sv
// Combinational biquad arithmetic for one sample: scaling, five products, rounding and saturation.
module dcnb_datapath (
    input  logic signed [dcnb_pkg::SAMPLE_W-1:0] sample_in,
    input  dcnb_pkg::coef_t                      coef,
    input  dcnb_pkg::hist_t                      hist,
    output dcnb_pkg::hist_t                      hist_next,
    output logic signed [dcnb_pkg::SAMPLE_W-1:0] sample_out
);

    localparam int XS_WIDE_W = dcnb_pkg::SAMPLE_W + dcnb_pkg::IN_SHIFT + 1;
    localparam int PX_W      = dcnb_pkg::COEF_W + dcnb_pkg::XH_W;
    localparam int PY_W      = dcnb_pkg::COEF_W + dcnb_pkg::YH_W;
    localparam int ACC_W     = PY_W + 3;
    localparam int YH_W      = dcnb_pkg::YH_W;
    localparam int OUT_W     = dcnb_pkg::SAMPLE_W;

    localparam logic signed [XS_WIDE_W-1:0] XS_MAX =
        XS_WIDE_W'((64'sd1 <<< (dcnb_pkg::XH_W - 1)) - 64'sd1);
    localparam logic signed [XS_WIDE_W-1:0] XS_MIN =
        XS_WIDE_W'(-(64'sd1 <<< (dcnb_pkg::XH_W - 1)));
    localparam logic signed [ACC_W-1:0] Y_MAX =
        ACC_W'((64'sd1 <<< (YH_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-(64'sd1 <<< (YH_W - 1)));
    localparam logic signed [ACC_W-1:0] COEF_BIAS =
        ACC_W'((64'sd1 <<< dcnb_pkg::COEF_SHIFT) - 64'sd1);
    localparam logic signed [YH_W-1:0] IN_BIAS =
        YH_W'((64'sd1 <<< dcnb_pkg::IN_SHIFT) - 64'sd1);
    localparam logic signed [YH_W-1:0] OUT_MAX = YH_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [YH_W-1:0] OUT_MIN = YH_W'(-(64'sd1 <<< (OUT_W - 1)));

    logic signed [XS_WIDE_W-1:0]      xs_wide;
    logic signed [dcnb_pkg::XH_W-1:0] xs;
    logic signed [PX_W-1:0]           p_b0;
    logic signed [PX_W-1:0]           p_b1x;
    logic signed [PX_W-1:0]           p_b2;
    logic signed [PY_W-1:0]           p_b1y;
    logic signed [PY_W-1:0]           p_a2;
    logic signed [ACC_W-1:0]          acc;
    logic signed [ACC_W-1:0]          acc_biased;
    logic signed [ACC_W-1:0]          quot;
    logic signed [YH_W-1:0]           y;
    logic signed [YH_W-1:0]           y_biased;
    logic signed [YH_W-1:0]           r;

    always_comb begin
        // Scaled input, saturated to the x history width.
        xs_wide = XS_WIDE_W'(sample_in) <<< dcnb_pkg::IN_SHIFT;
        if (xs_wide > XS_MAX) begin
            xs = dcnb_pkg::XH_W'(XS_MAX);
        end else if (xs_wide < XS_MIN) begin
            xs = dcnb_pkg::XH_W'(XS_MIN);
        end else begin
            xs = dcnb_pkg::XH_W'(xs_wide);
        end

        p_b0  = coef.b0 * xs;
        p_b1x = coef.b1 * hist.x1;
        p_b2  = coef.b2 * hist.x2;
        p_b1y = coef.b1 * hist.y1;
        p_a2  = coef.a2 * hist.y2;

        acc = ACC_W'(p_b0) + ACC_W'(p_b1x) + ACC_W'(p_b2) - ACC_W'(p_b1y) + ACC_W'(p_a2);

        // Adding scale minus one to negative sums makes the shift truncate toward zero.
        acc_biased = acc[ACC_W-1] ? acc + COEF_BIAS : acc;
        quot       = acc_biased >>> dcnb_pkg::COEF_SHIFT;
        if (quot > Y_MAX) begin
            y = YH_W'(Y_MAX);
        end else if (quot < Y_MIN) begin
            y = YH_W'(Y_MIN);
        end else begin
            y = YH_W'(quot);
        end

        y_biased = y[YH_W-1] ? y + IN_BIAS : y;
        r        = y_biased >>> dcnb_pkg::IN_SHIFT;
        if (r > OUT_MAX) begin
            sample_out = OUT_W'(OUT_MAX);
        end else if (r < OUT_MIN) begin
            sample_out = OUT_W'(OUT_MIN);
        end else begin
            sample_out = OUT_W'(r);
        end

        hist_next.x1 = xs;
        hist_next.x2 = hist.x1;
        hist_next.y1 = y;
        hist_next.y2 = hist.y1;
    end

endmodule

FILE: src/dcnb_checker.sv
// Port-level assertions for the notch biquad and the bind that attaches them.
module dcnb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dcnb_pkg::SAMPLE_W-1:0] m_tdata,
    input logic                          cfg_ready
);

    // Reset leaves no word pending on the output.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word pending right after reset");

    // With the output empty, the input register can always move, so input is taken.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // Configuration writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration channel not ready");

    // A stalled output word stays and keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word dropped or changed");

endmodule

bind dual_channel_notch_biquad dcnb_checker u_dcnb_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);
